### src/clmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clmb_pkg: shared types and constants of the cutoff link map builder
// Field widths, operation and status codes, register indexes, sequencer
// states and the control groups passed between the datapath modules.
// ----------------------------------------------------------------------------
package clmb_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MAX_NODES  = 64;
   localparam int DEF_COORD_BITS = 16;

   // port field widths
   localparam int FUNC_W    = 2;
   localparam int NODE_W    = 6;
   localparam int POS_W     = 16;
   localparam int NCOUNT_W  = 7;
   localparam int CUTOFF_W  = 34;
   localparam int PIDX_W    = 11;
   localparam int STAT_W    = 2;
   localparam int ADDED_W   = 11;
   localparam int CSR_IDX_W = 1;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_SAME  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF     = 1'd1;

   localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
   localparam logic [ADDED_W-1:0]  ADDED_MAX        = 11'd2047;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PMUL1,
      ST_PMUL2,
      ST_PIDX,
      ST_PFIN,
      ST_BRD,
      ST_BDIF,
      ST_BMUL,
      ST_BCMP,
      ST_BFIN
   } clmb_state_type;

   // shared multiply-accumulate unit control
   typedef struct packed {
      logic mul_en;
      logic acc_clr;
      logic acc_en;
   } mac_ctl_type;

   // link store write control
   typedef struct packed {
      logic we;
      logic wbit;
   } link_ctl_type;

endpackage

### src/cutoff_link_map_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cutoff_link_map_builder_core: unit-disk link map over node positions
// Holds one 3-D position per node and one link bit per node pair, and runs
// load, add, query and cutoff build operations through one shared
// multiply-accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_* and raise start; the item is taken at an edge where
//   start is high and busy is low. busy stays high while an item is at work.
//   Response: one item per request, shown for one cycle with rsp_valid high.
//   The receiver cannot stall; it must take the item in that cycle.
//   Registers: write node_count (index 0) or cutoff_squared (index 1) on the
//   csr_ channel while the block is idle; csr_ready is always high.
// Sequence:
//   load, and any rejected add/query (same node, index out of range) or build
//   (fewer than two nodes): answered in the cycle after the request is taken.
//   add/query: two passes through the shared multiplier form the packed pair
//   index, then the link store is accessed. build: for each pair i < j < n,
//   n = min(node_count, MAX_NODES), reads both positions, runs three squares
//   through the shared multiplier, then compares and updates the link bit.
// Reset:
//   After reset the link store is swept to zero, one bit per cycle, over all
//   MAX_NODES*(MAX_NODES-1)/2 bits (2016 at 64 nodes); busy is high
//   during the sweep. Register writes are taken during the sweep.
// ----------------------------------------------------------------------------
module cutoff_link_map_builder_core #(
   parameter int MAX_NODES  = clmb_pkg::DEF_MAX_NODES,
   parameter int COORD_BITS = clmb_pkg::DEF_COORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [clmb_pkg::FUNC_W-1:0]         req_func,
   input  logic [clmb_pkg::NODE_W-1:0]         req_node_a,
   input  logic [clmb_pkg::NODE_W-1:0]         req_node_b,
   input  logic signed [clmb_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [clmb_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [clmb_pkg::POS_W-1:0]   req_pos_z,
   // response channel
   output logic                                rsp_valid,
   output logic                                rsp_connected,
   output logic [clmb_pkg::PIDX_W-1:0]         rsp_pair_index,
   output logic [clmb_pkg::STAT_W-1:0]         rsp_status,
   output logic [clmb_pkg::ADDED_W-1:0]        rsp_links_added,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [clmb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [clmb_pkg::CUTOFF_W-1:0]       csr_wdata
);
   import clmb_pkg::*;

   // node index, node count and pair address widths
   localparam int IW   = $clog2(MAX_NODES);
   localparam int NNW  = $clog2(MAX_NODES + 1);
   localparam int CW   = (NNW > NCOUNT_W) ? NNW : NCOUNT_W;
   localparam int PAIR_COUNT = (MAX_NODES * (MAX_NODES - 1)) / 2;
   localparam int LAW  = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
   // coordinate, difference and multiplier widths
   localparam int CB   = COORD_BITS;
   localparam int DW   = CB + 1;
   localparam int FW   = (CB > POS_W) ? CB : POS_W;
   localparam int MW   = (DW > IW) ? DW : IW;
   localparam int PW2  = 2 * MW;
   localparam int AW   = PW2 + 2;
   localparam int CMPW = (AW > CUTOFF_W) ? AW : CUTOFF_W;

   // sequencer and registers
   clmb_state_type state_ff, state_in;

   logic [NCOUNT_W-1:0] node_count_ff, node_count_in;
   logic [CUTOFF_W-1:0] cutoff_ff, cutoff_in;

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [IW-1:0]       lo_ff, lo_in;
   logic [IW-1:0]       hi_ff, hi_in;
   logic [PW2-1:0]      t1_ff, t1_in;
   logic [LAW-1:0]      pidx_ff, pidx_in;
   logic [IW-1:0]       i_ff, i_in;
   logic [IW-1:0]       j_ff, j_in;
   logic [LAW-1:0]      bidx_ff, bidx_in;
   logic [1:0]          step_ff, step_in;
   logic [ADDED_W-1:0]  added_ff, added_in;
   logic [MW-1:0]       mag_ff [3];
   logic [MW-1:0]       mag_in [3];
   logic                lbit_ff, lbit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_conn_ff, rsp_conn_in;
   logic [PIDX_W-1:0]   rsp_pidx_ff, rsp_pidx_in;
   logic [STAT_W-1:0]   rsp_stat_ff, rsp_stat_in;
   logic [ADDED_W-1:0]  rsp_added_ff, rsp_added_in;

   // shared unit and memory hookups
   mac_ctl_type         mac_ctl;
   logic [MW-1:0]       mac_a;
   logic [MW-1:0]       mac_b;
   logic [PW2-1:0]      mac_prod;
   logic [AW-1:0]       mac_acc;

   logic                pos_we;
   logic [3*CB-1:0]     pos_wdata;
   logic [3*CB-1:0]     pos_rd0;
   logic [3*CB-1:0]     pos_rd1;

   link_ctl_type        link_ctl;
   logic [LAW-1:0]      link_waddr;
   logic [LAW-1:0]      link_raddr;
   logic                link_rdata;

   // decoded request
   logic                accept;
   logic [CW-1:0]       nc_ext;
   logic [CW-1:0]       n_act;
   logic [CW-1:0]       a_ext;
   logic [CW-1:0]       b_ext;
   logic                a_bad;
   logic                b_bad;
   logic [IW-1:0]       a_idx;
   logic [IW-1:0]       b_idx;
   logic [IW-1:0]       n_m1;
   logic [IW-1:0]       n_m2;
   logic                pair_ok;
   logic [FW-1:0]       raw_x;
   logic [FW-1:0]       raw_y;
   logic [FW-1:0]       raw_z;
   logic [PW2-1:0]      idx_full;
   logic [LAW-1:0]      pidx_c;
   logic signed [DW-1:0] dif [3];
   logic [DW-1:0]       mag_c [3];
   logic                hit;
   logic                last_pair;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // active node count saturates at the store depth
   assign nc_ext = CW'(node_count_ff);
   assign n_act  = (nc_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_ext;
   assign n_m1   = IW'(n_act - CW'(1));
   assign n_m2   = IW'(n_act - CW'(2));

   assign a_ext  = CW'(req_node_a);
   assign b_ext  = CW'(req_node_b);
   assign a_bad  = (a_ext >= n_act);
   assign b_bad  = (b_ext >= n_act);
   assign a_idx  = a_ext[IW-1:0];
   assign b_idx  = b_ext[IW-1:0];
   assign pair_ok = !a_bad && !b_bad && (a_idx != b_idx);

   // coordinates: zero-extend the field, then keep the low COORD_BITS bits
   assign raw_x     = FW'($unsigned(req_pos_x));
   assign raw_y     = FW'($unsigned(req_pos_y));
   assign raw_z     = FW'($unsigned(req_pos_z));
   assign pos_wdata = {raw_x[CB-1:0], raw_y[CB-1:0], raw_z[CB-1:0]};

   // packed index: lo*(n-1) - lo*(lo-1)/2 + (hi-lo-1)
   assign idx_full = t1_ff - (mac_prod >> 1) + PW2'(hi_ff - lo_ff - IW'(1));
   assign pidx_c   = LAW'(idx_full);

   // absolute coordinate differences of the pair just read
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dif[k]   = $signed({pos_rd0[k*CB + CB - 1], pos_rd0[k*CB +: CB]})
                  - $signed({pos_rd1[k*CB + CB - 1], pos_rd1[k*CB +: CB]});
         mag_c[k] = dif[k][DW-1] ? DW'(-dif[k]) : DW'(dif[k]);
      end
   end

   assign hit       = (CMPW'(mac_acc) < CMPW'(cutoff_ff)) && !lbit_ff;
   assign last_pair = (i_ff == n_m2) && (j_ff == n_m1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (bidx_ff == LAW'(PAIR_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_ADD, FUNC_QUERY: begin
                     if (pair_ok) begin
                        state_in = ST_PMUL1;
                     end
                  end
                  FUNC_BUILD: begin
                     if (n_act >= CW'(2)) begin
                        state_in = ST_BRD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PMUL1: state_in = ST_PMUL2;
         ST_PMUL2: state_in = ST_PIDX;
         ST_PIDX:  state_in = ST_PFIN;
         ST_PFIN:  state_in = ST_IDLE;
         ST_BRD:   state_in = ST_BDIF;
         ST_BDIF:  state_in = ST_BMUL;
         ST_BMUL: begin
            if (step_ff == 2'd3) begin
               state_in = ST_BCMP;
            end
         end
         ST_BCMP:  state_in = last_pair ? ST_BFIN : ST_BRD;
         ST_BFIN:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // unit and memory controls
   always_comb begin
      mac_ctl    = '0;
      mac_a      = '0;
      mac_b      = '0;
      pos_we     = 1'b0;
      link_ctl   = '0;
      link_waddr = bidx_ff;
      link_raddr = bidx_ff;
      case (state_ff)
         ST_CLEAR: begin
            link_ctl.we = 1'b1;
         end
         ST_IDLE: begin
            pos_we = accept && (req_func == FUNC_LOAD) && !a_bad;
         end
         ST_PMUL1: begin
            mac_ctl.mul_en = 1'b1;
            mac_a          = MW'(lo_ff);
            mac_b          = MW'(n_m1);
         end
         ST_PMUL2: begin
            // lo of zero wraps here, but the product stays zero
            mac_ctl.mul_en = 1'b1;
            mac_a          = MW'(lo_ff);
            mac_b          = MW'(lo_ff - IW'(1));
         end
         ST_PIDX: begin
            link_raddr    = pidx_c;
            link_waddr    = pidx_c;
            link_ctl.we   = (func_ff == FUNC_ADD);
            link_ctl.wbit = 1'b1;
         end
         ST_BMUL: begin
            mac_ctl.mul_en  = (step_ff != 2'd3);
            mac_ctl.acc_clr = (step_ff == 2'd0);
            mac_ctl.acc_en  = (step_ff != 2'd0);
            case (step_ff)
               2'd0:    mac_a = mag_ff[0];
               2'd1:    mac_a = mag_ff[1];
               2'd2:    mac_a = mag_ff[2];
               default: mac_a = '0;
            endcase
            mac_b = mac_a;
         end
         ST_BCMP: begin
            link_ctl.we   = hit;
            link_ctl.wbit = 1'b1;
         end
         default: begin
            link_ctl = '0;
         end
      endcase
   end

   // datapath and response registers
   always_comb begin
      node_count_in = node_count_ff;
      cutoff_in     = cutoff_ff;
      func_in       = func_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      t1_in         = t1_ff;
      pidx_in       = pidx_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      bidx_in       = bidx_ff;
      step_in       = step_ff;
      added_in      = added_ff;
      mag_in        = mag_ff;
      lbit_in       = lbit_ff;
      rsp_valid_in  = 1'b0;
      rsp_conn_in   = 1'b0;
      rsp_pidx_in   = '0;
      rsp_stat_in   = STAT_DONE;
      rsp_added_in  = '0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_in = csr_wdata[NCOUNT_W-1:0];
            CSR_CUTOFF:     cutoff_in     = csr_wdata;
            default:        cutoff_in     = cutoff_ff;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            bidx_in = bidx_ff + LAW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               lo_in    = (a_idx < b_idx) ? a_idx : b_idx;
               hi_in    = (a_idx < b_idx) ? b_idx : a_idx;
               i_in     = '0;
               j_in     = IW'(1);
               bidx_in  = '0;
               added_in = '0;
               case (req_func)
                  FUNC_LOAD: begin
                     rsp_valid_in = 1'b1;
                     rsp_stat_in  = a_bad ? STAT_RANGE : STAT_DONE;
                  end
                  FUNC_ADD, FUNC_QUERY: begin
                     // range check wins over the same-node check
                     if (a_bad || b_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_stat_in  = STAT_RANGE;
                     end else if (a_idx == b_idx) begin
                        rsp_valid_in = 1'b1;
                        rsp_stat_in  = STAT_SAME;
                     end
                  end
                  FUNC_BUILD: begin
                     // fewer than two nodes: no pairs to walk
                     if (n_act < CW'(2)) begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b0;
               endcase
            end
         end
         ST_PMUL2: begin
            t1_in = mac_prod;
         end
         ST_PIDX: begin
            pidx_in = pidx_c;
         end
         ST_PFIN: begin
            rsp_valid_in = 1'b1;
            rsp_pidx_in  = PIDX_W'(pidx_ff);
            rsp_conn_in  = (func_ff == FUNC_QUERY) ? link_rdata : 1'b0;
         end
         ST_BDIF: begin
            for (int k = 0; k < 3; k++) begin
               mag_in[k] = MW'(mag_c[k]);
            end
            lbit_in = link_rdata;
            step_in = 2'd0;
         end
         ST_BMUL: begin
            step_in = step_ff + 2'd1;
         end
         ST_BCMP: begin
            if (hit && (added_ff != ADDED_MAX)) begin
               added_in = added_ff + ADDED_W'(1);
            end
            // advance along the row, wrap to the next row's first pair
            bidx_in = bidx_ff + LAW'(1);
            if (j_ff == n_m1) begin
               i_in = i_ff + IW'(1);
               j_in = i_ff + IW'(2);
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         ST_BFIN: begin
            rsp_valid_in = 1'b1;
            rsp_added_in = added_ff;
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         bidx_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= NODE_COUNT_RESET;
         cutoff_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         bidx_ff       <= bidx_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
         cutoff_ff     <= cutoff_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      t1_ff        <= t1_in;
      pidx_ff      <= pidx_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      step_ff      <= step_in;
      added_ff     <= added_in;
      mag_ff       <= mag_in;
      lbit_ff      <= lbit_in;
      rsp_conn_ff  <= rsp_conn_in;
      rsp_pidx_ff  <= rsp_pidx_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_added_ff <= rsp_added_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_connected   = rsp_conn_ff;
   assign rsp_pair_index  = rsp_pidx_ff;
   assign rsp_status      = rsp_stat_ff;
   assign rsp_links_added = rsp_added_ff;

   clmb_mac #(
      .MW (MW)
   ) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .prod  (mac_prod),
      .acc   (mac_acc)
   );

   clmb_pos_mem #(
      .DEPTH (MAX_NODES),
      .AW    (IW),
      .DW    (3 * CB)
   ) u_pos_mem (
      .clock  (clock),
      .we     (pos_we),
      .waddr  (a_idx),
      .wdata  (pos_wdata),
      .raddr0 (i_ff),
      .raddr1 (j_ff),
      .rdata0 (pos_rd0),
      .rdata1 (pos_rd1)
   );

   clmb_link_mem #(
      .DEPTH (PAIR_COUNT),
      .AW    (LAW)
   ) u_link_mem (
      .clock (clock),
      .ctl   (link_ctl),
      .waddr (link_waddr),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

endmodule

### src/clmb_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clmb_mac: shared multiply-accumulate unit
// One registered unsigned multiplier followed by a registered accumulator.
// ----------------------------------------------------------------------------
module clmb_mac #(
   parameter int MW = 17
) (
   input  logic                    clock,
   input  clmb_pkg::mac_ctl_type   ctl,
   input  logic [MW-1:0]           op_a,
   input  logic [MW-1:0]           op_b,
   output logic [2*MW-1:0]         prod,
   output logic [2*MW+1:0]         acc
);
   import clmb_pkg::*;

   logic [2*MW-1:0] prod_ff;
   logic [2*MW-1:0] prod_in;
   logic [2*MW+1:0] acc_ff;
   logic [2*MW+1:0] acc_in;

   always_comb begin
      prod_in = ctl.mul_en ? op_a * op_b : prod_ff;
      if (ctl.acc_clr) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + (2*MW+2)'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

### src/clmb_pos_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clmb_pos_mem: node position store
// One write port and two registered read ports, one entry per node.
// ----------------------------------------------------------------------------
module clmb_pos_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 48
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr0,
   input  logic [AW-1:0] raddr1,
   output logic [DW-1:0] rdata0,
   output logic [DW-1:0] rdata1
);
   import clmb_pkg::*;

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata0_ff;
   logic [DW-1:0] rdata1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata0_ff <= mem[raddr0];
      rdata1_ff <= mem[raddr1];
   end

   assign rdata0 = rdata0_ff;
   assign rdata1 = rdata1_ff;

endmodule

### src/clmb_link_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clmb_link_mem: packed link bit store
// One bit per node pair, one write port and one registered read port.
// ----------------------------------------------------------------------------
module clmb_link_mem #(
   parameter int DEPTH = 2016,
   parameter int AW    = 11
) (
   input  logic                   clock,
   input  clmb_pkg::link_ctl_type ctl,
   input  logic [AW-1:0]          waddr,
   input  logic [AW-1:0]          raddr,
   output logic                   rdata
);
   import clmb_pkg::*;

   logic mem [DEPTH];
   logic rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[waddr] <= ctl.wbit;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
